### src/sap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg: shared types and constants of the shelf atlas packer
// field widths, shelf table sizing, register codes and the cell interface
// ----------------------------------------------------------------------------
package sap_pkg;

   localparam int MAX_SHELVES = 64;
   localparam int NUM_SLOTS   = 2;

   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int GUT_W      = 4;
   localparam int SLOT_W     = 1;
   localparam int CNT_W      = $clog2(MAX_SHELVES + 1);
   localparam int IDX_W      = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int GRP_SIZE   = 8;
   localparam int NUM_GROUPS = (MAX_SHELVES + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_PAD    = NUM_GROUPS * GRP_SIZE;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_SIZE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GUTTER     = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] ATLAS_SIZE_RST = DIM_W'(2048);
   localparam logic [GUT_W-1:0] GUTTER_RST     = GUT_W'(1);

   localparam logic REQ_PACK  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [DIM_W-1:0]  rect_width;
      logic [DIM_W-1:0]  rect_height;
      logic [SLOT_W-1:0] atlas_slot;
   } sap_req_type;

   typedef struct packed {
      logic             placed;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } sap_rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              fit_en;
      logic              grp_en;
      logic              sel_en;
      logic              upd_hit;
      logic              flush;
      logic [SLOT_W-1:0] slot;
      logic [DIM_W-1:0]  rect_width;
      logic [DIM_W-1:0]  rect_height;
      logic [DIM_W-1:0]  atlas_size;
      logic [GUT_W-1:0]  gutter;
      logic [DIM_W-1:0]  new_top;
   } sap_cmd_type;

   // what a cell reports back
   typedef struct packed {
      logic             fit;
      logic [DIM_W-1:0] hit_fill;
      logic [DIM_W-1:0] hit_top;
   } sap_stat_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W+1:0] v);
      logic [DIM_W+1:0] lim;
      lim = {2'b00, {DIM_W{1'b1}}};
      return (v > lim) ? {DIM_W{1'b1}} : v[DIM_W-1:0];
   endfunction

endpackage

### src/sap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_cell: one shelf position of the packer row
// holds one shelf per slot, tests it against the request and passes a
// first-fit claim bit to its right neighbor
// ----------------------------------------------------------------------------
module sap_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sap_pkg::sap_cmd_type cmd,
   input  logic                 open_we,
   input  logic                 prior_in,
   input  logic                 grp_win,
   output logic                 prior_out,
   output sap_pkg::sap_stat_type stat
);
   import sap_pkg::*;

   logic [NUM_SLOTS-1:0] live_ff, live_in;
   logic [DIM_W-1:0]     top_ff  [NUM_SLOTS];
   logic [DIM_W-1:0]     tall_ff [NUM_SLOTS];
   logic [DIM_W-1:0]     fill_ff [NUM_SLOTS];
   logic                 fit_ff, fit_in;
   logic                 first_ff, first_in;
   logic                 win_ff, win_in;

   logic [DIM_W-1:0] cur_top;
   logic [DIM_W-1:0] cur_tall;
   logic [DIM_W-1:0] cur_fill;
   logic [DIM_W:0]   fill_end;
   logic             fit_now;

   always_comb begin
      cur_top  = top_ff[cmd.slot];
      cur_tall = tall_ff[cmd.slot];
      cur_fill = fill_ff[cmd.slot];
      fill_end = {1'b0, cur_fill} + {1'b0, cmd.rect_width};
      fit_now  = live_ff[cmd.slot] && (cmd.rect_height <= cur_tall) &&
                 (fill_end <= {1'b0, cmd.atlas_size});

      fit_in   = cmd.fit_en ? fit_now : fit_ff;
      first_in = cmd.grp_en ? (fit_ff && !prior_in) : first_ff;
      win_in   = cmd.sel_en ? (first_ff && grp_win) : win_ff;

      live_in = live_ff;
      if (cmd.flush) begin
         live_in = '0;
      end else if (open_we) begin
         live_in[cmd.slot] = 1'b1;
      end
   end

   // claim ripples within the group
   assign prior_out     = prior_in || fit_ff;
   assign stat.fit      = fit_ff;
   assign stat.hit_fill = win_ff ? cur_fill : '0;
   assign stat.hit_top  = win_ff ? cur_top : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      fit_ff   <= fit_in;
      first_ff <= first_in;
      win_ff   <= win_in;
      if (open_we) begin
         top_ff[cmd.slot]  <= cmd.new_top;
         tall_ff[cmd.slot] <= cmd.rect_height;
         fill_ff[cmd.slot] <= sat_dim((DIM_W+2)'(cmd.rect_width) + (DIM_W+2)'(cmd.gutter));
      end else if (cmd.upd_hit && win_ff) begin
         fill_ff[cmd.slot] <= sat_dim((DIM_W+2)'(cur_fill) + (DIM_W+2)'(cmd.rect_width) +
                                      (DIM_W+2)'(cmd.gutter));
      end
   end

endmodule

### src/shelf_atlas_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_atlas_packer: first-fit shelf packer for a square glyph atlas
// two independent slots, each with a row of shelves held in a chain of cells
// ----------------------------------------------------------------------------
// an accepted start leads to the one-cycle rsp_strobe, registered in the update state
// no new word is taken while busy; the four steps fit, group claim,
//   select and update walk the cell row once per word
// busy is high from acceptance until the cycle of rsp_strobe
// reset: shelf counts and cell live flags clear at once, atlas_size 2048,
//   gutter 1; shelf contents are not cleared and no sweep follows reset
// the receiver cannot stall: every result shows for exactly one cycle
module shelf_atlas_packer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sap_pkg::sap_req_type           req_word,
   output logic                           rsp_strobe,
   output sap_pkg::sap_rsp_type           rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sap_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sap_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIT,
      ST_GRP,
      ST_SEL,
      ST_UPD
   } state_type;

   // control state and registered outputs
   state_type        state_ff, state_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   sap_rsp_type      rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0] count_ff [NUM_SLOTS];
   logic [CNT_W-1:0] count_in [NUM_SLOTS];
   logic [DIM_W-1:0] atlas_size_ff, atlas_size_in;
   logic [GUT_W-1:0] gutter_ff, gutter_in;

   // datapath registers
   sap_req_type           req_ff;
   logic [DIM_W-1:0]      last_bottom_ff [NUM_SLOTS];
   logic [NUM_GROUPS-1:0] grp_any_ff;
   logic                  any_hit_ff;
   logic [DIM_W:0]        new_top_ff;
   logic                  new_ok_ff;

   // cell row
   sap_cmd_type            cmd;
   sap_stat_type           stat     [MAX_SHELVES];
   logic [MAX_SHELVES-1:0] prior_out;
   logic [MAX_SHELVES-1:0] open_dec;
   logic [GRP_PAD-1:0]     fit_pad;
   logic [NUM_GROUPS-1:0]  grp_win;

   logic             accept;
   logic [CNT_W-1:0] n_cur;
   logic             slot_ok;
   logic             pack_ok;
   logic             upd_hit;
   logic             upd_open;
   logic [DIM_W:0]   new_top_calc;
   logic             new_ok_calc;
   logic [DIM_W-1:0] hit_fill;
   logic [DIM_W-1:0] hit_top;
   logic             grp_seen;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // request decode for the word in flight
   always_comb begin
      n_cur   = count_ff[req_ff.atlas_slot];
      slot_ok = (int'(req_ff.atlas_slot) < NUM_SLOTS);
      pack_ok = (req_ff.req_type == REQ_PACK) && slot_ok;

      // a new shelf goes one gutter below the last one, or at row 0
      if (n_cur == '0) begin
         new_top_calc = '0;
      end else begin
         new_top_calc = {1'b0, last_bottom_ff[req_ff.atlas_slot]} + (DIM_W+1)'(gutter_ff);
      end
      new_ok_calc = (n_cur < CNT_W'(MAX_SHELVES)) &&
                    (({1'b0, new_top_calc} + (DIM_W+2)'(req_ff.rect_height)) <=
                     (DIM_W+2)'(atlas_size_ff));

      upd_hit  = (state_ff == ST_UPD) && pack_ok && any_hit_ff;
      upd_open = (state_ff == ST_UPD) && pack_ok && !any_hit_ff && new_ok_ff;
   end

   // broadcast to the cells
   always_comb begin
      cmd.fit_en      = (state_ff == ST_FIT);
      cmd.grp_en      = (state_ff == ST_GRP);
      cmd.sel_en      = (state_ff == ST_SEL);
      cmd.upd_hit     = upd_hit;
      cmd.flush       = (state_ff == ST_UPD) && (req_ff.req_type == REQ_FLUSH);
      cmd.slot        = req_ff.atlas_slot;
      cmd.rect_width  = req_ff.rect_width;
      cmd.rect_height = req_ff.rect_height;
      cmd.atlas_size  = atlas_size_ff;
      cmd.gutter      = gutter_ff;
      cmd.new_top     = new_top_ff[DIM_W-1:0];
   end

   // the row of shelf cells; claim bits ripple inside groups of GRP_SIZE
   for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
      logic prior_in;
      if ((i % GRP_SIZE) == 0) begin : g_head
         assign prior_in = 1'b0;
      end else begin : g_link
         assign prior_in = prior_out[i-1];
      end

      assign open_dec[i] = upd_open && (n_cur[IDX_W-1:0] == IDX_W'(i));

      sap_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .open_we   (open_dec[i]),
         .prior_in  (prior_in),
         .grp_win   (grp_win[i / GRP_SIZE]),
         .prior_out (prior_out[i]),
         .stat      (stat[i])
      );
   end

   // fit flags padded out to whole groups
   always_comb begin
      fit_pad = '0;
      for (int i = 0; i < MAX_SHELVES; i++) begin
         fit_pad[i] = stat[i].fit;
      end
   end

   // first group with any fitting shelf wins
   always_comb begin
      grp_seen = 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_win[g] = grp_any_ff[g] && !grp_seen;
         grp_seen   = grp_seen || grp_any_ff[g];
      end
   end

   // only the winning cell drives nonzero data
   always_comb begin
      hit_fill = '0;
      hit_top  = '0;
      for (int i = 0; i < MAX_SHELVES; i++) begin
         hit_fill = hit_fill | stat[i].hit_fill;
         hit_top  = hit_top | stat[i].hit_top;
      end
   end

   // next state, result word, shelf counts and registers
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      count_in      = count_ff;
      atlas_size_in = atlas_size_ff;
      gutter_in     = gutter_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            state_in = ST_GRP;
         end
         ST_GRP: begin
            state_in = ST_SEL;
         end
         ST_SEL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '0;
            if (req_ff.req_type == REQ_FLUSH) begin
               for (int s = 0; s < NUM_SLOTS; s++) begin
                  count_in[s] = '0;
               end
            end else if (upd_hit) begin
               rsp_word_in.placed = 1'b1;
               rsp_word_in.pos_x  = hit_fill[POS_W-1:0];
               rsp_word_in.pos_y  = hit_top[POS_W-1:0];
            end else if (upd_open) begin
               rsp_word_in.placed = 1'b1;
               rsp_word_in.pos_y  = new_top_ff[POS_W-1:0];
               count_in[req_ff.atlas_slot] = n_cur + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATLAS_SIZE: atlas_size_in = csr_wdata[DIM_W-1:0];
            CSR_GUTTER:     gutter_in     = csr_wdata[GUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         rsp_word_ff   <= '0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            count_ff[s] <= '0;
         end
         atlas_size_ff <= ATLAS_SIZE_RST;
         gutter_ff     <= GUTTER_RST;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_word_ff   <= rsp_word_in;
         count_ff      <= count_in;
         atlas_size_ff <= atlas_size_in;
         gutter_ff     <= gutter_in;
      end
   end

   // datapath: request capture, new shelf check, group summaries
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (state_ff == ST_FIT) begin
         new_top_ff <= new_top_calc;
         new_ok_ff  <= new_ok_calc;
      end
      if (state_ff == ST_GRP) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any_ff[g] <= |fit_pad[g*GRP_SIZE +: GRP_SIZE];
         end
      end
      if (state_ff == ST_SEL) begin
         any_hit_ff <= |grp_any_ff;
      end
      // bottom edge of the newest shelf, stays within atlas_size
      if (upd_open) begin
         last_bottom_ff[req_ff.atlas_slot] <= DIM_W'(new_top_ff + (DIM_W+1)'(req_ff.rect_height));
      end
   end

endmodule

### src/sap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_port_props: port-level checks of the shelf atlas packer
// watches the command and result ports over time
// ----------------------------------------------------------------------------
module sap_port_props (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input sap_pkg::sap_req_type req_word,
   input logic                 rsp_strobe,
   input sap_pkg::sap_rsp_type rsp_word
);
   import sap_pkg::*;

   // an accepted word keeps the block busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted word");

   // a result ends the busy period
   a_rsp_done : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a busy period");

   // a failed or flush result carries a zero position
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.placed) |-> (rsp_word.pos_x == '0 && rsp_word.pos_y == '0))
      else $error("unplaced result with a nonzero position");

   // a flush is answered by an unplaced result
   a_flush_rsp : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.req_type == REQ_FLUSH) |-> ##5 (rsp_strobe && !rsp_word.placed))
      else $error("flush result missing or placed");

endmodule

bind shelf_atlas_packer sap_port_props u_sap_port_props (.*);

### test/sap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_checker: placement predictor and result scoreboard for the atlas packer
// mirrors the shelf tables and registers, predicts every accepted word and
// compares each strobed result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module sap_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  sap_pkg::sap_req_type           req_word,
   input  logic                           rsp_strobe,
   input  sap_pkg::sap_rsp_type           rsp_word,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sap_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             error_count,
   output int                             pending_count
);
   import sap_pkg::*;

   localparam int FILL_MAX = (1 << DIM_W) - 1;

   logic [DIM_W-1:0] atlas_side;
   logic [GUT_W-1:0] gap_px;
   logic [DIM_W-1:0] row_top  [NUM_SLOTS][MAX_SHELVES];
   logic [DIM_W-1:0] row_tall [NUM_SLOTS][MAX_SHELVES];
   logic [DIM_W-1:0] row_fill [NUM_SLOTS][MAX_SHELVES];
   int               row_count [NUM_SLOTS];
   sap_rsp_type      placements_due [$];
   int               mismatches;

   initial begin
      error_count   = 0;
      pending_count = 0;
      mismatches    = 0;
   end

   // first fit over the open shelves, else a new shelf under the last one
   function automatic sap_rsp_type place_rect(input sap_req_type r);
      sap_rsp_type res;
      int s, n, w, h, i, top, grown;
      res = '0;
      if (r.req_type == REQ_FLUSH) begin
         foreach (row_count[k]) row_count[k] = 0;
         return res;
      end
      s = int'(r.atlas_slot);
      if (s >= NUM_SLOTS) return res;
      n = (row_count[s] > MAX_SHELVES) ? MAX_SHELVES : row_count[s];
      w = int'(r.rect_width);
      h = int'(r.rect_height);
      for (i = 0; i < n; i++) begin
         if (h <= int'(row_tall[s][i]) && int'(row_fill[s][i]) + w <= int'(atlas_side)) begin
            res.placed = 1'b1;
            res.pos_x  = row_fill[s][i][POS_W-1:0];
            res.pos_y  = row_top[s][i][POS_W-1:0];
            grown = int'(row_fill[s][i]) + w + int'(gap_px);
            row_fill[s][i] = (grown > FILL_MAX) ? DIM_W'(FILL_MAX) : DIM_W'(grown);
            return res;
         end
      end
      top = 0;
      if (n > 0)
         top = int'(row_top[s][n-1]) + int'(row_tall[s][n-1]) + int'(gap_px);
      if (n >= MAX_SHELVES || top + h > int'(atlas_side)) return res;
      grown = w + int'(gap_px);
      row_top[s][n]  = DIM_W'(top);
      row_tall[s][n] = DIM_W'(h);
      row_fill[s][n] = (grown > FILL_MAX) ? DIM_W'(FILL_MAX) : DIM_W'(grown);
      row_count[s]   = n + 1;
      res.placed = 1'b1;
      res.pos_y  = POS_W'(top);
      return res;
   endfunction

   task automatic report(input string field, input int want, input int got);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      sap_rsp_type want;
      if (reset) begin
         atlas_side = ATLAS_SIZE_RST;
         gap_px     = GUTTER_RST;
         foreach (row_count[k]) row_count[k] = 0;
         placements_due.delete();
      end else begin
         // a result always belongs to an older word, so retire before predicting
         if (rsp_strobe) begin
            if (placements_due.size() == 0) begin
               report("unexpected result, placed", 0, int'(rsp_word.placed));
            end else begin
               want = placements_due.pop_front();
               if (rsp_word.placed !== want.placed)
                  report("placed", int'(want.placed), int'(rsp_word.placed));
               if (rsp_word.pos_x !== want.pos_x)
                  report("pos_x", int'(want.pos_x), int'(rsp_word.pos_x));
               if (rsp_word.pos_y !== want.pos_y)
                  report("pos_y", int'(want.pos_y), int'(rsp_word.pos_y));
            end
         end
         if (start && !busy)
            placements_due.push_back(place_rect(req_word));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ATLAS_SIZE: atlas_side = csr_wdata[DIM_W-1:0];
               CSR_GUTTER:     gap_px     = csr_wdata[GUT_W-1:0];
               default: ;
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= placements_due.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the shelf atlas packer
// directed corner words, then random pack and flush traffic over several
// atlas sizes and gutters, with random sender gaps; checking is in sap_checker
// ----------------------------------------------------------------------------
module tb_top;
   import sap_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   sap_req_type           req_word  = '0;
   logic                  rsp_strobe;
   sap_rsp_type           rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ATLAS_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int pending_count;
   int words_sent = 0;
   int cur_side   = 2048;   // atlas side currently programmed, shapes random sizes

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   shelf_atlas_packer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sap_checker watch (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   function automatic sap_req_type pack(input int w, input int h, input int slot);
      sap_req_type r;
      r             = '0;
      r.req_type    = REQ_PACK;
      r.rect_width  = DIM_W'(w);
      r.rect_height = DIM_W'(h);
      r.atlas_slot  = SLOT_W'(slot);
      return r;
   endfunction

   // flush ignores the other fields, so fill them with noise
   function automatic sap_req_type flush_word();
      sap_req_type r;
      r          = pack($urandom_range(4096), $urandom_range(4096), $urandom_range(1));
      r.req_type = REQ_FLUSH;
      return r;
   endfunction

   function automatic int pick_edge(input int side);
      case ($urandom_range(3))
         0:       return 0;
         1:       return 1;
         2:       return side;
         default: return 4096;
      endcase
   endfunction

   // mostly glyph-like sizes so shelves fill up and get reused,
   // with a tail of large, full-range and edge sizes
   function automatic sap_req_type pick_word(input int side);
      int roll, slot, w, h;
      roll = $urandom_range(99);
      slot = $urandom_range(NUM_SLOTS - 1);
      if (roll < 4)
         return flush_word();
      if (roll < 70) begin
         w = $urandom_range((side / 6 > 1) ? side / 6 : 1);
         h = $urandom_range((side / 10 > 1) ? side / 10 : 1);
      end else if (roll < 88) begin
         w = $urandom_range(side);
         h = $urandom_range(side);
      end else if (roll < 96) begin
         w = $urandom_range(4096);
         h = $urandom_range(4096);
      end else begin
         w = pick_edge(side);
         h = pick_edge(side);
      end
      return pack(w, h, slot);
   endfunction

   // one word through the start/busy handshake; start stays high when the
   // next word follows at once, so it may sit high across busy
   task automatic send_word(input sap_req_type r);
      int idle_pct;
      idle_pct = (words_sent < 134) ? 34 : ((words_sent < 267) ? 74 : 0);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_word(pick_word(cur_side));
   endtask

   // drop start and wait until every predicted result has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_atlas(input int side, input int gap);
      settle();
      write_reg(CSR_ATLAS_SIZE, side);
      write_reg(CSR_GUTTER, gap);
      cur_side = side;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: side 2048, gutter 1
      send_word(flush_word());            // flush of an empty atlas
      send_word(pack(0, 0, 0));           // zero-size rect opens the first shelf
      send_word(pack(10, 20, 0));         // too tall for shelf 0, opens shelf 1
      send_word(pack(10, 5, 0));          // first fit into shelf 1
      send_word(pack(4096, 4096, 1));     // past the bottom edge, fails
      send_word(pack(2048, 2048, 1));     // exactly fills the atlas height
      send_word(pack(1, 1, 1));           // nowhere left in slot 1
      send_word(pack(4096, 8, 0));        // wide new shelf, width unchecked
      send_word(pack(1, 8, 0));           // first fit into shelf 1, ahead of the overfull wide shelf
      send_word(pack(2037, 20, 0));       // fill plus width overruns shelf 1, opens a new shelf
      send_word(flush_word());            // both slots empty again
      send_word(pack(3, 3, 1));
      send_word(pack(4096, 0, 0));
      send_word(pack(7, 4096, 0));
      send_random(70);

      // widest atlas, no gutter: coordinates reach 4096 and wrap to 12 bits
      program_atlas(4096, 0);
      send_word(flush_word());
      send_word(pack(4096, 4096, 0));     // fill becomes 4096
      send_word(pack(0, 0, 0));           // x of 4096 on shelf 0
      send_word(pack(1, 0, 0));           // new shelf with top 4096
      send_word(pack(4095, 4095, 1));
      send_word(pack(1, 1, 1));
      send_random(70);

      // smallest atlas, largest gutter: nearly everything fails
      program_atlas(1, 15);
      send_word(pack(1, 1, 0));
      send_word(pack(1, 1, 0));
      send_random(40);

      // flat full-width rects open one shelf each until the table is full
      program_atlas(64, 0);
      send_word(flush_word());
      repeat (MAX_SHELVES + 2) send_word(pack(64, 0, 1));
      send_word(pack(0, 0, 1));           // every shelf holds fill 64, still fits at x 64
      send_word(pack(1, 0, 0));           // slot 0 unaffected
      send_random(40);

      // assorted settings
      repeat (3) begin
         program_atlas($urandom_range(4096, 1), $urandom_range(15));
         send_random(30);
      end

      settle();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
